// File: rtl/core/udr_pkg.sv
// udr_pkg: shared types and constants for the UDP destination rewrite block.
// No dependencies.
package udr_pkg;

  localparam int WORD_W  = 64;
  localparam int COUNT_W = 4;
  localparam int MAC_W   = 48;
  localparam int IP_W    = 32;
  localparam int PORT_W  = 16;
  localparam int CSUM_W  = 21;  // room for the widest IPv4 header sum

  localparam logic [1:0] REG_TARGET_MAC  = 2'd0;
  localparam logic [1:0] REG_TARGET_IP   = 2'd1;
  localparam logic [1:0] REG_TARGET_PORT = 2'd2;

  localparam logic [7:0]  ETH_TYPE_HI  = 8'h08;
  localparam logic [7:0]  ETH_TYPE_LO  = 8'h00;
  localparam logic [7:0]  PROTO_UDP    = 8'd17;
  localparam logic [3:0]  IHL_MIN      = 4'd5;
  localparam logic [3:0]  FULL_COUNT   = 4'd8;

  typedef struct packed {
    logic [MAC_W-1:0]  mac;
    logic [IP_W-1:0]   ip;
    logic [PORT_W-1:0] port;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_COLLECT = 4'b0001,
    ST_EMIT    = 4'b0010,
    ST_PASS    = 4'b0100,
    ST_DROP    = 4'b1000
  } state_t;

endpackage

// File: rtl/core/udp_destination_rewrite.sv
// udp_destination_rewrite: IPv4/UDP destination rewrite on an 8-byte word stream.
// Header words are held until the UDP header is complete; the state register then
// enters emit and rewritten words leave through the output register, one word per
// cycle from the cell chain while the output is not stalled. Passing: one word per
// cycle while not stalled; input stalls while the chain drains through its head cell.
// Reset (rst, synchronous): config and counters cleared, block collecting a new frame.
module udp_destination_rewrite #(
  parameter int HEADER_WORDS = 11
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [1:0]                  cfg_index,
  input  logic [udr_pkg::MAC_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [udr_pkg::WORD_W-1:0]  data_word,
  input  logic [udr_pkg::COUNT_W-1:0] byte_count,
  input  logic                        frame_end,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [udr_pkg::WORD_W-1:0]  out_word,
  output logic [udr_pkg::COUNT_W-1:0] out_count,
  output logic                        out_end
);

  localparam int FILL_W = $clog2(HEADER_WORDS + 1);

  // configuration
  udr_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        udr_pkg::REG_TARGET_MAC:  cfg.mac  <= cfg_data;
        udr_pkg::REG_TARGET_IP:   cfg.ip   <= cfg_data[udr_pkg::IP_W-1:0];
        udr_pkg::REG_TARGET_PORT: cfg.port <= cfg_data[udr_pkg::PORT_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  udr_pkg::state_t state;
  logic [FILL_W-1:0]          fill;
  logic [FILL_W-1:0]          emit_idx;
  logic [6:0]                 byte_position;
  logic [3:0]                 header_len_words;
  logic [udr_pkg::CSUM_W-1:0] csum_acc;
  logic                       emit_end;
  logic [3:0]                 emit_cnt;

  // chain of header cells, head at cell 0
  logic [udr_pkg::WORD_W-1:0] cell_word [HEADER_WORDS];
  logic                       collect_acc;
  logic                       shift;

  for (genvar i = 0; i < HEADER_WORDS; i++) begin : g_cell
    logic [udr_pkg::WORD_W-1:0] nb;
    if (i == HEADER_WORDS - 1) begin : g_tail
      assign nb = '0;
    end else begin : g_mid
      assign nb = cell_word[i+1];
    end
    udr_cell u_cell (
      .clk       (clk),
      .capture   (collect_acc && (fill == FILL_W'(i))),
      .shift     (shift),
      .in_word   (data_word),
      .neighbour (nb),
      .word      (cell_word[i])
    );
  end

  // effective count: out-of-range codes mean a full word
  logic [3:0] cnt;
  assign cnt = (byte_count == 4'd0 || byte_count > udr_pkg::FULL_COUNT) ?
               udr_pkg::FULL_COUNT : byte_count;

  logic load;
  assign load = !out_valid || out_ready;

  always_comb begin
    case (state)
      udr_pkg::ST_COLLECT: in_ready = 1'b1;
      udr_pkg::ST_DROP:    in_ready = 1'b1;
      udr_pkg::ST_PASS:    in_ready = load;
      default:             in_ready = 1'b0;
    endcase
  end

  logic accept;
  assign accept      = in_valid && in_ready;
  assign collect_acc = accept && (state == udr_pkg::ST_COLLECT) &&
                       (fill < FILL_W'(HEADER_WORDS));
  assign shift       = (state == udr_pkg::ST_EMIT) && load;

  // header checks on the word just completing the store
  logic [6:0]  bp_next;
  logic [63:0] w1, w2;
  logic [3:0]  ihl;
  logic [6:0]  need;
  logic        hdr_bad, hdr_done;

  always_comb begin
    bp_next  = byte_position + (frame_end ? {3'b000, cnt} : 7'd8);
    w1       = (fill == FILL_W'(1)) ? data_word : cell_word[1];
    w2       = (fill == FILL_W'(2)) ? data_word : cell_word[2];
    ihl      = w1[11:8];
    need     = 7'd22 + {1'b0, ihl, 2'b00};
    hdr_bad  = 1'b0;
    hdr_done = 1'b0;
    if (bp_next >= 7'd15) begin
      if (ihl < udr_pkg::IHL_MIN || w1[31:24] != udr_pkg::ETH_TYPE_HI ||
          w1[23:16] != udr_pkg::ETH_TYPE_LO) begin
        hdr_bad = 1'b1;
      end else if (bp_next >= 7'd24 && w2[7:0] != udr_pkg::PROTO_UDP) begin
        hdr_bad = 1'b1;
      end else if (bp_next >= need) begin
        hdr_done = 1'b1;
      end
    end
  end

  // IPv4 header sum of this word's 16-bit lanes, after rewrite of the IP
  // destination and with the checksum field taken as zero
  logic [udr_pkg::CSUM_W-1:0] lane_sum;
  logic [7:0]  lp;
  logic [15:0] lv;
  logic        incl;

  always_comb begin
    lane_sum = '0;
    lp       = '0;
    lv       = '0;
    incl     = 1'b0;
    for (int j = 0; j < 4; j++) begin
      lp = 8'({fill, 3'b000}) + 8'(2 * j);
      lv = data_word[63-16*j -: 16];
      if (fill == FILL_W'(3) && j == 0) lv = 16'h0000;
      if (fill == FILL_W'(3) && j == 3) lv = cfg.ip[31:16];
      if (fill == FILL_W'(4) && j == 0) lv = cfg.ip[15:0];
      incl = (fill == FILL_W'(1) && j == 3) ||
             (fill >= FILL_W'(2) && lp < 8'd14 + {2'b00, header_len_words, 2'b00});
      if (incl) lane_sum = lane_sum + udr_pkg::CSUM_W'(lv);
    end
  end

  // fold and invert
  logic [16:0] fold1, fold2;
  logic [15:0] csum;
  assign fold1 = {1'b0, csum_acc[15:0]} + 17'(csum_acc[udr_pkg::CSUM_W-1:16]);
  assign fold2 = {1'b0, fold1[15:0]} + 17'(fold1[16]);
  assign csum  = ~fold2[15:0];

  logic [udr_pkg::WORD_W-1:0] rw_word;
  udr_rewrite u_rewrite (
    .word     (cell_word[0]),
    .idx      (4'(emit_idx)),
    .ihl      (header_len_words),
    .cfg      (cfg),
    .csum     (csum),
    .new_word (rw_word)
  );

  logic emit_last;
  assign emit_last = (emit_idx + FILL_W'(1)) == fill;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (shift || (accept && state == udr_pkg::ST_PASS)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      out_word  <= rw_word;
      out_count <= (emit_last && emit_end) ? emit_cnt : udr_pkg::FULL_COUNT;
      out_end   <= emit_last && emit_end;
    end else if (accept && state == udr_pkg::ST_PASS) begin
      out_word  <= data_word;
      out_count <= cnt;
      out_end   <= frame_end;
    end
  end

  // frame sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= udr_pkg::ST_COLLECT;
      fill             <= '0;
      emit_idx         <= '0;
      byte_position    <= '0;
      header_len_words <= '0;
      csum_acc         <= '0;
      emit_end         <= 1'b0;
      emit_cnt         <= udr_pkg::FULL_COUNT;
    end else begin
      case (state)
        udr_pkg::ST_COLLECT: begin
          if (accept) begin
            if (!collect_acc) begin
              // store full: drop the rest of the frame
              if (!frame_end) state <= udr_pkg::ST_DROP;
              fill          <= '0;
              byte_position <= '0;
              csum_acc      <= '0;
            end else begin
              fill          <= fill + FILL_W'(1);
              byte_position <= bp_next;
              csum_acc      <= csum_acc + lane_sum;
              if (bp_next >= 7'd15) header_len_words <= ihl;
              if (hdr_done) begin
                state    <= udr_pkg::ST_EMIT;
                emit_idx <= '0;
                emit_end <= frame_end;
                emit_cnt <= cnt;
              end else if (hdr_bad || frame_end) begin
                // bad header or short frame
                if (!frame_end) state <= udr_pkg::ST_DROP;
                fill          <= '0;
                byte_position <= '0;
                csum_acc      <= '0;
              end
            end
          end
        end
        udr_pkg::ST_EMIT: begin
          if (shift) begin
            emit_idx <= emit_idx + FILL_W'(1);
            if (emit_last) begin
              state         <= emit_end ? udr_pkg::ST_COLLECT : udr_pkg::ST_PASS;
              fill          <= '0;
              byte_position <= '0;
              csum_acc      <= '0;
            end
          end
        end
        udr_pkg::ST_PASS: begin
          if (accept && frame_end) state <= udr_pkg::ST_COLLECT;
        end
        udr_pkg::ST_DROP: begin
          if (accept && frame_end) state <= udr_pkg::ST_COLLECT;
        end
        default: state <= udr_pkg::ST_COLLECT;
      endcase
    end
  end

endmodule

// File: rtl/core/udr_cell.sv
// udr_cell: one header store cell, captures an input word or takes its
// neighbour's word when the chain shifts. Uses udr_pkg.
module udr_cell (
  input  logic                       clk,
  input  logic                       capture,
  input  logic                       shift,
  input  logic [udr_pkg::WORD_W-1:0] in_word,
  input  logic [udr_pkg::WORD_W-1:0] neighbour,
  output logic [udr_pkg::WORD_W-1:0] word
);

  always_ff @(posedge clk) begin
    if (shift) begin
      word <= neighbour;
    end else if (capture) begin
      word <= in_word;
    end
  end

endmodule

// File: rtl/core/udr_rewrite.sv
// udr_rewrite: patches MAC, IP destination, checksum and UDP fields into the
// header word leaving the head of the chain. Uses udr_pkg.
module udr_rewrite (
  input  logic [udr_pkg::WORD_W-1:0] word,
  input  logic [3:0]                 idx,
  input  logic [3:0]                 ihl,
  input  udr_pkg::cfg_t              cfg,
  input  logic [15:0]                csum,
  output logic [udr_pkg::WORD_W-1:0] new_word
);

  logic [6:0] p;
  logic [6:0] port_pos;
  logic [6:0] ucsum_pos;

  always_comb begin
    new_word  = word;
    port_pos  = 7'd16 + {1'b0, ihl, 2'b00};
    ucsum_pos = 7'd20 + {1'b0, ihl, 2'b00};
    p         = '0;
    if (idx == 4'd0) begin
      new_word[63:16] = cfg.mac;
    end
    if (idx == 4'd3) begin
      new_word[63:48] = csum;
      new_word[15:0]  = cfg.ip[31:16];
    end
    if (idx == 4'd4) begin
      new_word[63:48] = cfg.ip[15:0];
    end
    for (int j = 0; j < 4; j++) begin
      p = {idx, 3'b000} + 7'(2 * j);
      if (p == port_pos) begin
        new_word[63-16*j -: 16] = cfg.port;
      end
      if (p == ucsum_pos) begin
        new_word[63-16*j -: 16] = 16'h0000;
      end
    end
  end

endmodule
